/* rtl/lrut_pkg.sv */
// shared types, codes and widths for the lru frame residency tracker
// no dependencies; used by the cell, the chain and the top level
`default_nettype none

package lrut_pkg;

	localparam int IDX_W       = 10;
	localparam int ACT_W       = 2;
	localparam int STAT_W      = 3;
	localparam int RCNT_W      = 5;
	localparam int BLIM_W      = 4;
	localparam int FCNT_W      = 11;
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 16;

	localparam int CAPACITY_DEF   = 16;
	localparam int MAX_FRAMES_DEF = 1024;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_STORE  = 2'd1,
		ACT_ERASE  = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_HIT      = 3'd0,
		STAT_MISS     = 3'd1,
		STAT_STORED   = 3'd2,
		STAT_REJECTED = 3'd3,
		STAT_ERASED   = 3'd4,
		STAT_NOT_RES  = 3'd5,
		STAT_CLEARED  = 3'd6,
		STAT_EVICTED  = 3'd7
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CACHE_ENABLE   = 2'd0,
		REG_BUFFERED_LIMIT = 2'd1,
		REG_FRAME_COUNT    = 2'd2
	} cfg_reg_t;

	// what every cell of the chain does in this cycle
	typedef enum logic [2:0] {
		CO_HOLD,
		CO_PROMOTE,
		CO_CLOSE,
		CO_PUSH_FRONT,
		CO_PUSH_BACK
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  key;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/lrut_cell.sv */
// one slot of the recency chain: holds a frame index, compares it with the key
// and takes its value from a neighbour or the key; uses lrut_pkg
`default_nettype none

module lrut_cell #(
	parameter int CNT_W = 5,
	parameter int POS   = 0
) (
	input  wire                          clk,
	input  wire lrut_pkg::cell_ctl_t     ctl,
	input  wire [CNT_W-1:0]              count,
	input  wire [lrut_pkg::IDX_W-1:0]    prev_val,
	input  wire [lrut_pkg::IDX_W-1:0]    next_val,
	input  wire                          seen_in,
	output logic                         seen_out,
	output logic [lrut_pkg::IDX_W-1:0]   val
);

	logic [lrut_pkg::IDX_W-1:0] val_q;
	logic [lrut_pkg::IDX_W-1:0] val_nxt;
	logic                       occ;
	logic                       hit;

	assign occ      = CNT_W'(POS) < count;
	assign hit      = occ && (val_q == ctl.key);
	assign seen_out = seen_in | hit;
	assign val      = val_q;

	always_comb begin
		val_nxt = val_q;
		unique case (ctl.op)
			lrut_pkg::CO_HOLD: val_nxt = val_q;
			// slots up to and including the hit move one place back
			lrut_pkg::CO_PROMOTE: begin
				if (!seen_in) val_nxt = prev_val;
			end
			// slots from the hit onwards close the gap
			lrut_pkg::CO_CLOSE: begin
				if (seen_out) val_nxt = next_val;
			end
			lrut_pkg::CO_PUSH_FRONT: val_nxt = prev_val;
			lrut_pkg::CO_PUSH_BACK: begin
				if (CNT_W'(POS) == count) val_nxt = ctl.key;
			end
			default: val_nxt = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule

`default_nettype wire

/* rtl/lrut_chain.sv */
// row of lrut_cell slots, most recent at slot 0; the hit flag ripples along it
// depends on lrut_pkg and lrut_cell
`default_nettype none

module lrut_chain #(
	parameter int CAPACITY = lrut_pkg::CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire                                       clk,
	input  wire lrut_pkg::cell_ctl_t                  ctl,
	input  wire [CNT_W-1:0]                           count,
	output logic [CAPACITY-1:0][lrut_pkg::IDX_W-1:0]  vals,
	output logic                                      hit
);

	logic [CAPACITY:0] seen;

	assign seen[0] = 1'b0;
	assign hit     = seen[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [lrut_pkg::IDX_W-1:0] prev_v;
		logic [lrut_pkg::IDX_W-1:0] next_v;

		if (i == 0) begin : g_head
			assign prev_v = ctl.key;
		end else begin : g_body
			assign prev_v = vals[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_v = vals[i];
		end else begin : g_inner
			assign next_v = vals[i+1];
		end

		lrut_cell #(
			.CNT_W (CNT_W),
			.POS   (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count),
			.prev_val (prev_v),
			.next_val (next_v),
			.seen_in  (seen[i]),
			.seen_out (seen[i+1]),
			.val      (vals[i])
		);
	end

endmodule

`default_nettype wire

/* rtl/lru_frame_residency_tracker_core.sv */
// top level of the lru frame residency tracker: stream ports, control sequencer
// and output register; depends on lrut_pkg and lrut_chain
`default_nettype none

// Keeps up to CAPACITY resident frame indices in recency order in a chain of
// cells, most recent first. Each request on the slave stream gives one or more
// results on the master stream, the final one flagged by tlast. A lookup, erase
// or clear is taken in the idle state, then matched along the chain with the
// list update in the match state. An accepted store then goes to the evict
// state, where the sequencer removes one victim from the back of the chain per
// cycle while the output register is free, before inserting; a rejected store
// ends in the match state. A result that is due waits while the output register
// is still full. One request is in progress at a time; the next is taken once
// the last result of the current one sits in the output register. Resident
// slots are tracked by the count alone, so no clearing pass runs after reset.
module lru_frame_residency_tracker_core #(
	parameter int CAPACITY   = lrut_pkg::CAPACITY_DEF,
	parameter int MAX_FRAMES = lrut_pkg::MAX_FRAMES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// frame_index [9:0], insert_at_front [10], has_data [11], zero fill
	input  wire [lrut_pkg::S_TDATA_W-1:0]    s_tdata,
	// action [1:0]
	input  wire [lrut_pkg::ACT_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// result_index [9:0], resident_count [14:10], zero fill
	output logic [lrut_pkg::M_TDATA_W-1:0]   m_tdata,
	// status [2:0]
	output logic [lrut_pkg::STAT_W-1:0]      m_tuser,
	output logic                             m_tlast,
	input  wire                              cfg_we,
	input  wire [lrut_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [lrut_pkg::CFG_W-1:0]        cfg_data
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SEL_W = $clog2(CAPACITY);
	localparam int LW    = (CNT_W > lrut_pkg::BLIM_W + 1) ? CNT_W : lrut_pkg::BLIM_W + 1;
	localparam int VW    = $clog2(MAX_FRAMES + 1) + lrut_pkg::FCNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_EVICT
	} state_t;

	state_t state_q;

	// configuration
	logic                        cache_en_q;
	logic [lrut_pkg::BLIM_W-1:0] blimit_q;
	logic [lrut_pkg::FCNT_W-1:0] fcount_q;

	// request being worked on
	lrut_pkg::action_t           act_q;
	logic [lrut_pkg::IDX_W-1:0]  idx_q;
	logic                        front_q;
	logic                        has_data_q;

	logic [CNT_W-1:0]            count_q;

	// output register
	logic                        out_valid_q;
	lrut_pkg::status_t           out_stat_q;
	logic [lrut_pkg::IDX_W-1:0]  out_idx_q;
	logic [lrut_pkg::RCNT_W-1:0] out_cnt_q;
	logic                        out_last_q;

	lrut_pkg::cell_ctl_t                      ctl;
	logic [CAPACITY-1:0][lrut_pkg::IDX_W-1:0] vals;
	logic                                     hit;

	logic                        s_xfer;
	logic                        out_free;
	logic                        idx_ok;
	logic [LW-1:0]               lim_raw;
	logic [LW-1:0]               limit;
	logic                        evict_now;
	logic [CNT_W-1:0]            count_dec;
	logic [SEL_W-1:0]            victim_sel;
	logic                        store_ok;
	logic                        out_load;

	lrut_pkg::status_t           out_stat_d;
	logic [lrut_pkg::IDX_W-1:0]  out_idx_d;
	logic [lrut_pkg::RCNT_W-1:0] out_cnt_d;
	logic                        out_last_d;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign idx_ok    = (VW'(idx_q) < VW'(fcount_q)) && (VW'(idx_q) < VW'(MAX_FRAMES));
	assign lim_raw   = LW'(blimit_q) + LW'(1);
	assign limit     = (lim_raw > LW'(CAPACITY)) ? LW'(CAPACITY) : lim_raw;
	assign evict_now = (LW'(count_q) >= limit) && (count_q != '0);
	assign count_dec = count_q - CNT_W'(1);
	assign victim_sel = count_dec[SEL_W-1:0];

	assign store_ok  = (act_q == lrut_pkg::ACT_STORE) && cache_en_q && idx_ok && has_data_q;
	// accepted store produces nothing in the match cycle
	assign out_load  = out_free && ((state_q == ST_MATCH && !store_ok) || state_q == ST_EVICT);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = lrut_pkg::M_TDATA_W'({out_cnt_q, out_idx_q});

	// chain command for this cycle
	always_comb begin
		ctl.op  = lrut_pkg::CO_HOLD;
		ctl.key = idx_q;
		if (out_free) begin
			unique case (state_q)
				ST_MATCH: begin
					unique case (act_q)
						lrut_pkg::ACT_LOOKUP: begin
							if (cache_en_q && idx_ok && hit) ctl.op = lrut_pkg::CO_PROMOTE;
						end
						lrut_pkg::ACT_STORE: begin
							if (cache_en_q && idx_ok && has_data_q && hit)
								ctl.op = lrut_pkg::CO_CLOSE;
						end
						lrut_pkg::ACT_ERASE: begin
							if (idx_ok && hit) ctl.op = lrut_pkg::CO_CLOSE;
						end
						lrut_pkg::ACT_CLEAR: ctl.op = lrut_pkg::CO_HOLD;
						default: ctl.op = lrut_pkg::CO_HOLD;
					endcase
				end
				ST_EVICT: begin
					if (!evict_now)
						ctl.op = front_q ? lrut_pkg::CO_PUSH_FRONT : lrut_pkg::CO_PUSH_BACK;
				end
				default: ctl.op = lrut_pkg::CO_HOLD;
			endcase
		end
	end

	lrut_chain #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.count (count_q),
		.vals  (vals),
		.hit   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_en_q <= 1'b0;
			blimit_q   <= '0;
			fcount_q   <= '0;
		end else if (cfg_we) begin
			unique case (lrut_pkg::cfg_reg_t'(cfg_index))
				lrut_pkg::REG_CACHE_ENABLE:   cache_en_q <= cfg_data[0];
				lrut_pkg::REG_BUFFERED_LIMIT: blimit_q   <= cfg_data[lrut_pkg::BLIM_W-1:0];
				lrut_pkg::REG_FRAME_COUNT:    fcount_q   <= cfg_data[lrut_pkg::FCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			act_q      <= lrut_pkg::action_t'(s_tuser);
			idx_q      <= s_tdata[lrut_pkg::IDX_W-1:0];
			front_q    <= s_tdata[lrut_pkg::IDX_W];
			has_data_q <= s_tdata[lrut_pkg::IDX_W+1];
		end
	end

	// next result
	always_comb begin
		out_stat_d = lrut_pkg::STAT_MISS;
		out_idx_d  = idx_q;
		out_cnt_d  = lrut_pkg::RCNT_W'(count_q);
		out_last_d = 1'b1;
		unique case (state_q)
			ST_MATCH: begin
				unique case (act_q)
					lrut_pkg::ACT_LOOKUP: begin
						out_stat_d = (cache_en_q && idx_ok && hit) ? lrut_pkg::STAT_HIT
						                                           : lrut_pkg::STAT_MISS;
					end
					lrut_pkg::ACT_STORE: out_stat_d = lrut_pkg::STAT_REJECTED;
					lrut_pkg::ACT_ERASE: begin
						if (idx_ok && hit) begin
							out_stat_d = lrut_pkg::STAT_ERASED;
							out_cnt_d  = lrut_pkg::RCNT_W'(count_dec);
						end else begin
							out_stat_d = lrut_pkg::STAT_NOT_RES;
						end
					end
					lrut_pkg::ACT_CLEAR: begin
						out_stat_d = lrut_pkg::STAT_CLEARED;
						out_idx_d  = '0;
						out_cnt_d  = '0;
					end
					default: out_stat_d = lrut_pkg::STAT_MISS;
				endcase
			end
			ST_EVICT: begin
				if (evict_now) begin
					out_stat_d = lrut_pkg::STAT_EVICTED;
					out_idx_d  = vals[victim_sel];
					out_cnt_d  = lrut_pkg::RCNT_W'(count_dec);
					out_last_d = 1'b0;
				end else begin
					out_stat_d = lrut_pkg::STAT_STORED;
					out_cnt_d  = lrut_pkg::RCNT_W'(count_q + CNT_W'(1));
				end
			end
			default: out_stat_d = lrut_pkg::STAT_MISS;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_stat_q <= out_stat_d;
			out_idx_q  <= out_idx_d;
			out_cnt_q  <= out_cnt_d;
			out_last_q <= out_last_d;
		end
	end

	// sequencer, resident count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					if (out_free) begin
						state_q <= store_ok ? ST_EVICT : ST_IDLE;
						unique case (act_q)
							lrut_pkg::ACT_LOOKUP: ;
							lrut_pkg::ACT_STORE: begin
								if (store_ok && hit) count_q <= count_dec;
							end
							lrut_pkg::ACT_ERASE: begin
								if (idx_ok && hit) count_q <= count_dec;
							end
							lrut_pkg::ACT_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				ST_EVICT: begin
					if (out_free) begin
						if (evict_now) begin
							count_q <= count_dec;
						end else begin
							count_q <= count_q + CNT_W'(1);
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("resident count above capacity");

	a_evict_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == lrut_pkg::STAT_EVICTED) |-> !m_tlast)
		else $error("eviction flagged as final result");

	a_store_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT && out_free && !evict_now) |=> (count_q != '0 && m_tvalid))
		else $error("store left the list empty or gave no result");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && out_free && $past(state_q) == ST_EVICT && !s_tready
		 && state_q == ST_EVICT && !evict_now) |=> s_tready)
		else $error("sequencer did not return to idle after store");

endmodule

`default_nettype wire

/* tb/sv/lru_frame_residency_tracker_core_test.sv */
// self-checking testbench for lru_frame_residency_tracker_core: directed table, then random phases
// depends on lrut_pkg and the rtl of the core; keeps its own recency list to predict every result
`default_nettype none

module lru_frame_residency_tracker_core_test;
	import lrut_pkg::*;

	localparam int CAP        = CAPACITY_DEF;
	localparam int HOLD_CYC   = 240;
	localparam int PHASES     = 10;
	localparam int PHASE_LEN  = 30;

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] frame;
		logic [RCNT_W-1:0] count;
		logic             last;
	} outcome_t;

	// one row of the directed script: either a register setting or a request, sent rep times
	typedef struct packed {
		logic              reconfig;
		logic              en;
		logic [BLIM_W-1:0] lim;
		logic [FCNT_W-1:0] fc;
		action_t           act;
		logic [IDX_W-1:0]  frame;
		logic              front;
		logic              has_data;
		logic [4:0]        rep;
		logic              typed;
		status_t           want_status;
		logic [IDX_W-1:0]  want_frame;
		logic [RCNT_W-1:0] want_count;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	wire                   s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [ACT_W-1:0]      s_tuser;
	wire                   m_tvalid;
	logic                  m_tready;
	wire  [M_TDATA_W-1:0]  m_tdata;
	wire  [STAT_W-1:0]     m_tuser;
	wire                   m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	// shadow of the block: registers and recency list, most recent at slot 0
	bit                    en_shadow;
	logic [BLIM_W-1:0]     limit_shadow;
	logic [FCNT_W-1:0]     frames_shadow;
	logic [IDX_W-1:0]      recency [CAP];
	int                    resident;

	outcome_t              due_results [$];
	int                    mismatches;
	int                    results_seen;
	bit                    hold_req;

	script_row_t script [0:20] = '{
		// reset settings: disabled, no valid frames
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_LOOKUP, 10'd0, 1'b0, 1'b1, 5'd1,
			1'b1, STAT_MISS, 10'd0, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd1023, 1'b1, 1'b1, 5'd1,
			1'b1, STAT_REJECTED, 10'd1023, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_ERASE, 10'd1023, 1'b0, 1'b0, 5'd1,
			1'b1, STAT_NOT_RES, 10'd1023, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_CLEAR, 10'd1023, 1'b1, 1'b1, 5'd1,
			1'b1, STAT_CLEARED, 10'd0, 5'd0},
		'{1'b1, 1'b1, 4'd15, 11'd1024, ACT_LOOKUP, 10'd0, 1'b0, 1'b0, 5'd0,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		// empty entry is refused
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd1023, 1'b0, 1'b0, 5'd1,
			1'b1, STAT_REJECTED, 10'd1023, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd1023, 1'b1, 1'b1, 5'd1,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		// fill to capacity from the back
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd0, 1'b0, 1'b1, 5'd15,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		// restore of a resident frame, then a store that evicts one
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd1023, 1'b1, 1'b1, 5'd1,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd500, 1'b1, 1'b1, 5'd1,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_LOOKUP, 10'd0, 1'b0, 1'b0, 5'd1,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_LOOKUP, 10'd14, 1'b1, 1'b1, 5'd1,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		// shrink the limit to one: next store drains the whole list
		'{1'b1, 1'b1, 4'd0, 11'd1024, ACT_LOOKUP, 10'd0, 1'b0, 1'b0, 5'd0,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd777, 1'b1, 1'b1, 5'd1,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd778, 1'b0, 1'b1, 5'd1,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		// disabled, and the resident frame now out of range
		'{1'b1, 1'b0, 4'd15, 11'd2, ACT_LOOKUP, 10'd0, 1'b0, 1'b0, 5'd0,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_LOOKUP, 10'd778, 1'b0, 1'b1, 5'd1,
			1'b1, STAT_MISS, 10'd778, 5'd1},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_STORE, 10'd1, 1'b1, 1'b1, 5'd1,
			1'b1, STAT_REJECTED, 10'd1, 5'd1},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_ERASE, 10'd778, 1'b0, 1'b1, 5'd1,
			1'b1, STAT_NOT_RES, 10'd778, 5'd1},
		// erase still works while disabled
		'{1'b1, 1'b0, 4'd15, 11'd1024, ACT_LOOKUP, 10'd0, 1'b0, 1'b0, 5'd0,
			1'b0, STAT_HIT, 10'd0, 5'd0},
		'{1'b0, 1'b0, 4'd0, 11'd0, ACT_ERASE, 10'd778, 1'b1, 1'b0, 5'd1,
			1'b1, STAT_ERASED, 10'd778, 5'd0}
	};

	lru_frame_residency_tracker_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#15000000;
		$display("Simulation FAILED");
		$finish;
	end

	// mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(15, 40);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
		mismatches++;
	endtask

	function automatic void note_result(status_t st, logic [IDX_W-1:0] f, logic last);
		outcome_t o;
		o.status = st;
		o.frame  = f;
		o.count  = resident[RCNT_W-1:0];
		o.last   = last;
		due_results.insert(due_results.size(), o);
	endfunction

	function automatic int find_frame(logic [IDX_W-1:0] f);
		for (int i = 0; i < resident; i++)
			if (recency[i] == f)
				return i;
		return -1;
	endfunction

	function automatic void drop_at(int p);
		for (int i = p; i + 1 < resident; i++)
			recency[i] = recency[i + 1];
		resident--;
	endfunction

	function automatic void insert_front(logic [IDX_W-1:0] f);
		for (int i = resident; i > 0; i--)
			recency[i] = recency[i - 1];
		recency[0] = f;
		resident++;
	endfunction

	// works out the results of one accepted request and updates the shadow list
	function automatic void track_request(action_t act, logic [IDX_W-1:0] f, bit front, bit hd);
		bit in_range;
		int p;
		int lim;
		in_range = ({1'b0, f} < frames_shadow);
		case (act)
			ACT_LOOKUP: begin
				p = in_range ? find_frame(f) : -1;
				if (!en_shadow || p < 0) begin
					note_result(STAT_MISS, f, 1'b1);
				end else begin
					drop_at(p);
					insert_front(f);
					note_result(STAT_HIT, f, 1'b1);
				end
			end
			ACT_STORE: begin
				lim = int'(limit_shadow) + 1;
				if (lim > CAP)
					lim = CAP;
				if (!en_shadow || !in_range || !hd) begin
					note_result(STAT_REJECTED, f, 1'b1);
				end else begin
					p = find_frame(f);
					if (p >= 0)
						drop_at(p);
					while (resident >= lim && resident > 0) begin
						resident--;
						note_result(STAT_EVICTED, recency[resident], 1'b0);
					end
					if (front) begin
						insert_front(f);
					end else begin
						recency[resident] = f;
						resident++;
					end
					note_result(STAT_STORED, f, 1'b1);
				end
			end
			ACT_ERASE: begin
				p = in_range ? find_frame(f) : -1;
				if (p < 0) begin
					note_result(STAT_NOT_RES, f, 1'b1);
				end else begin
					drop_at(p);
					note_result(STAT_ERASED, f, 1'b1);
				end
			end
			default: begin
				resident = 0;
				note_result(STAT_CLEARED, '0, 1'b1);
			end
		endcase
	endfunction

	task automatic send_request(action_t act, logic [IDX_W-1:0] f, bit front, bit hd);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - IDX_W - 2){1'b0}}, hd, front, f};
		s_tuser  <= act;
		do
			@(posedge clk);
		while (!s_tready);
		track_request(act, f, front, hd);
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic write_registers(bit en, logic [BLIM_W-1:0] lim, logic [FCNT_W-1:0] fc);
		write_reg(REG_CACHE_ENABLE, CFG_W'(en));
		write_reg(REG_BUFFERED_LIMIT, CFG_W'(lim));
		write_reg(REG_FRAME_COUNT, fc);
		en_shadow     = en;
		limit_shadow  = lim;
		frames_shadow = fc;
	endtask

	// receiver: random runs of ready and gaps, or one long hold when asked
	initial begin
		int run;
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLD_CYC - 1) @(negedge clk);
			end else begin
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
				@(negedge clk);
				m_tready <= 1'b1;
				repeat (run - 1) @(negedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					@(negedge clk);
					m_tready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing pending, status", m_tuser, 0);
			end else begin
				want = due_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", m_tuser, want.status);
				if (m_tdata[IDX_W-1:0] !== want.frame)
					report_mismatch("result_index", m_tdata[IDX_W-1:0], want.frame);
				if (m_tdata[IDX_W+RCNT_W-1:IDX_W] !== want.count)
					report_mismatch("resident_count", m_tdata[IDX_W+RCNT_W-1:IDX_W], want.count);
				if (m_tlast !== want.last)
					report_mismatch("tlast", m_tlast, want.last);
			end
		end
	end

	initial begin
		outcome_t typed_res;
		bit en;
		logic [BLIM_W-1:0] lim;
		logic [FCNT_W-1:0] fc;
		int span;
		int r;
		logic [IDX_W-1:0] f;
		action_t act;

		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = ACT_LOOKUP;
		cfg_we        = 1'b0;
		cfg_index     = REG_CACHE_ENABLE;
		cfg_data      = '0;
		hold_req      = 1'b0;
		mismatches    = 0;
		results_seen  = 0;
		en_shadow     = 1'b0;
		limit_shadow  = '0;
		frames_shadow = '0;
		resident      = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		for (int row = 0; row < $size(script); row++) begin
			if (script[row].reconfig) begin
				settle();
				write_registers(script[row].en, script[row].lim, script[row].fc);
			end else begin
				for (int k = 0; k < script[row].rep; k++) begin
					send_request(script[row].act, script[row].frame + IDX_W'(k),
						script[row].front, script[row].has_data);
					// single-result rows with a value known by hand replace the prediction
					if (script[row].typed) begin
						typed_res.status = script[row].want_status;
						typed_res.frame  = script[row].want_frame;
						typed_res.count  = script[row].want_count;
						typed_res.last   = 1'b1;
						due_results.delete(due_results.size() - 1);
						due_results.insert(due_results.size(), typed_res);
					end
				end
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			en = ($urandom_range(0, 9) != 0);
			case ($urandom_range(0, 3))
				0: lim = '0;
				1: lim = '1;
				default: lim = BLIM_W'($urandom_range(0, 15));
			endcase
			// small pool of frames so that hits and evictions are common
			span = $urandom_range(int'(lim) + 2, int'(lim) + 20);
			r = $urandom_range(0, 9);
			if (r == 0)
				fc = '0;
			else if (r < 3)
				fc = FCNT_W'($urandom_range(0, 1023));
			else if (r < 5)
				fc = FCNT_W'(span);
			else
				fc = 11'd1024;
			write_registers(en, lim, fc);
			if (ph == 2)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph == 5 && n == PHASE_LEN / 2)
					settle();
				r = $urandom_range(0, 99);
				if (r < 38)
					act = ACT_LOOKUP;
				else if (r < 75)
					act = ACT_STORE;
				else if (r < 93)
					act = ACT_ERASE;
				else
					act = ACT_CLEAR;
				r = $urandom_range(0, 99);
				if (r < 75)
					f = IDX_W'($urandom_range(0, span));
				else if (r < 87 && resident > 0)
					f = recency[$urandom_range(0, resident - 1)];
				else
					f = IDX_W'($urandom_range(0, 1023));
				send_request(act, f, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
			end
		end

		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
